// File: hw/rtl/aif_pkg.sv
// Shared types and constants for the affine inverse datapath.
package aif_pkg;

  localparam int unsigned ONE_SHIFT_DEF = 16;
  localparam int unsigned LANES = 6;
  localparam int unsigned COEF_W = 32;
  localparam int unsigned DIV_W = 64;
  // Quotient bits kept per lane; the top bit only flags overflow.
  localparam int unsigned Q_W = 34;
  localparam int unsigned REM_W = DIV_W + Q_W;
  localparam logic [COEF_W-1:0] DET_MIN_RST = 32'd4295;

  typedef struct packed {
    logic                               valid;
    logic                               sing;
    logic [LANES-1:0]                   neg;
    logic [DIV_W-1:0]                   dmag;
    logic [LANES-1:0][REM_W-1:0]        rem;
    logic [LANES-1:0][Q_W-1:0]          quo;
  } aif_flow_t;

endpackage

// File: hw/rtl/aif_front.sv
// Front end: products, determinant, singular check and scaled numerators.
module aif_front #(
  parameter int unsigned ONE_SHIFT = aif_pkg::ONE_SHIFT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [aif_pkg::COEF_W-1:0]       det_min_i,
  input  logic signed [aif_pkg::COEF_W-1:0] coef_a_i,
  input  logic signed [aif_pkg::COEF_W-1:0] coef_b_i,
  input  logic signed [aif_pkg::COEF_W-1:0] coef_c_i,
  input  logic signed [aif_pkg::COEF_W-1:0] coef_d_i,
  input  logic signed [aif_pkg::COEF_W-1:0] coef_e_i,
  input  logic signed [aif_pkg::COEF_W-1:0] coef_f_i,
  output aif_pkg::aif_flow_t               flow_o
);
  import aif_pkg::*;

  localparam int unsigned P_W = 2 * COEF_W;

  logic                    vld_q;
  logic signed [P_W-1:0]   p_ae_q, p_bd_q, p_bf_q, p_ec_q, p_dc_q, p_af_q;
  logic signed [COEF_W-1:0] a_q, b_q, d_q, e_q;

  logic signed [P_W:0]     det_s, tc_s, tf_s;
  logic [P_W:0]            det_m, tc_m, tf_m;
  logic [COEF_W-1:0]       a_m, b_m, d_m, e_m;
  aif_flow_t               flow_d, flow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    p_ae_q <= coef_a_i * coef_e_i;
    p_bd_q <= coef_b_i * coef_d_i;
    p_bf_q <= coef_b_i * coef_f_i;
    p_ec_q <= coef_e_i * coef_c_i;
    p_dc_q <= coef_d_i * coef_c_i;
    p_af_q <= coef_a_i * coef_f_i;
    a_q <= coef_a_i;
    b_q <= coef_b_i;
    d_q <= coef_d_i;
    e_q <= coef_e_i;
  end

  always_comb begin
    det_s = {p_ae_q[P_W-1], p_ae_q} - {p_bd_q[P_W-1], p_bd_q};
    tc_s  = {p_bf_q[P_W-1], p_bf_q} - {p_ec_q[P_W-1], p_ec_q};
    tf_s  = {p_dc_q[P_W-1], p_dc_q} - {p_af_q[P_W-1], p_af_q};
    det_m = det_s[P_W] ? -det_s : det_s;
    tc_m  = tc_s[P_W] ? -tc_s : tc_s;
    tf_m  = tf_s[P_W] ? -tf_s : tf_s;
    a_m   = a_q[COEF_W-1] ? -a_q : a_q;
    b_m   = b_q[COEF_W-1] ? -b_q : b_q;
    d_m   = d_q[COEF_W-1] ? -d_q : d_q;
    e_m   = e_q[COEF_W-1] ? -e_q : e_q;

    flow_d.valid = vld_q;
    flow_d.sing  = (det_m == '0) || (det_m < {{(P_W+1-COEF_W){1'b0}}, det_min_i});
    flow_d.dmag  = det_m[DIV_W-1:0];
    flow_d.quo   = '0;
    // Result sign is the numerator sign against the determinant sign.
    flow_d.neg[0] = e_q[COEF_W-1] ^ det_s[P_W];
    flow_d.neg[1] = ~b_q[COEF_W-1] ^ det_s[P_W];
    flow_d.neg[2] = tc_s[P_W] ^ det_s[P_W];
    flow_d.neg[3] = ~d_q[COEF_W-1] ^ det_s[P_W];
    flow_d.neg[4] = a_q[COEF_W-1] ^ det_s[P_W];
    flow_d.neg[5] = tf_s[P_W] ^ det_s[P_W];
    flow_d.rem[0] = {{(REM_W-COEF_W){1'b0}}, e_m} << (COEF_W/2 + ONE_SHIFT);
    flow_d.rem[1] = {{(REM_W-COEF_W){1'b0}}, b_m} << (COEF_W/2 + ONE_SHIFT);
    flow_d.rem[2] = {{(REM_W-P_W-1){1'b0}}, tc_m} << ONE_SHIFT;
    flow_d.rem[3] = {{(REM_W-COEF_W){1'b0}}, d_m} << (COEF_W/2 + ONE_SHIFT);
    flow_d.rem[4] = {{(REM_W-COEF_W){1'b0}}, a_m} << (COEF_W/2 + ONE_SHIFT);
    flow_d.rem[5] = {{(REM_W-P_W-1){1'b0}}, tf_m} << ONE_SHIFT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_q <= '0;
    end else begin
      flow_q <= flow_d;
    end
  end

  assign flow_o = flow_q;

endmodule

// File: hw/rtl/aif_div_cell.sv
// One restoring-division cell: decides one quotient bit for all six lanes.
module aif_div_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  aif_pkg::aif_flow_t flow_i,
  output aif_pkg::aif_flow_t flow_o
);
  import aif_pkg::*;

  aif_flow_t        flow_d, flow_q;
  logic [REM_W:0]   dsh;
  logic [REM_W:0]   diff [LANES];

  always_comb begin
    flow_d = flow_i;
    dsh = {{(REM_W+1-DIV_W){1'b0}}, flow_i.dmag} << SHIFT;
    for (int l = 0; l < LANES; l++) begin
      diff[l] = {1'b0, flow_i.rem[l]} - dsh;
      if (!diff[l][REM_W]) begin
        flow_d.rem[l] = diff[l][REM_W-1:0];
        flow_d.quo[l][SHIFT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_q <= '0;
    end else begin
      flow_q <= flow_d;
    end
  end

  assign flow_o = flow_q;

endmodule

// File: hw/rtl/aif_round.sv
// Rounding, saturation and singular masking of the six quotients.
module aif_round (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  aif_pkg::aif_flow_t                    flow_i,
  output logic                                  valid_o,
  output logic                                  singular_o,
  output logic [aif_pkg::LANES-1:0][aif_pkg::COEF_W-1:0] res_o
);
  import aif_pkg::*;

  localparam logic [Q_W:0] POS_MAX = (Q_W+1)'(32'h7FFF_FFFF);
  localparam logic [Q_W:0] NEG_MAX = (Q_W+1)'(32'h8000_0000);

  logic                              vld_q, sing_q;
  logic [LANES-1:0][COEF_W-1:0]      res_d, res_q;
  logic [Q_W:0]                      qr [LANES];
  logic                              up [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      // Half away from zero: round up when twice the remainder reaches the divisor.
      up[l] = {flow_i.rem[l][DIV_W-1:0], 1'b0} >= {1'b0, flow_i.dmag};
      qr[l] = {1'b0, flow_i.quo[l]} + {{Q_W{1'b0}}, up[l]};
      if (flow_i.sing) begin
        res_d[l] = '0;
      end else if (flow_i.neg[l]) begin
        res_d[l] = (qr[l] > NEG_MAX) ? NEG_MAX[COEF_W-1:0] : -qr[l][COEF_W-1:0];
      end else begin
        res_d[l] = (qr[l] > POS_MAX) ? POS_MAX[COEF_W-1:0] : qr[l][COEF_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= flow_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    sing_q <= flow_i.sing;
    res_q  <= res_d;
  end

  assign valid_o    = vld_q;
  assign singular_o = sing_q;
  assign res_o      = res_q;

endmodule

// File: hw/rtl/affine_inverse_fixed_point.sv
// valid_o follows the edge that accepts start_i through 37 register stages.
// Throughput: one matrix per cycle; busy_o is always low and results are never stalled.
// The rate is set by the 34-cell division chain, which moves every transaction one cell a cycle.
// Reset clears all pipeline valid flags and loads det_min with its default of 4295.
// Results leave on valid_o for exactly one cycle; the receiver cannot hold them off.
module affine_inverse_fixed_point #(
  parameter int unsigned ONE_SHIFT = aif_pkg::ONE_SHIFT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              det_min_we_i,
  input  logic [aif_pkg::COEF_W-1:0]        det_min_i,
  input  logic signed [aif_pkg::COEF_W-1:0] coef_a_i,
  input  logic signed [aif_pkg::COEF_W-1:0] coef_b_i,
  input  logic signed [aif_pkg::COEF_W-1:0] coef_c_i,
  input  logic signed [aif_pkg::COEF_W-1:0] coef_d_i,
  input  logic signed [aif_pkg::COEF_W-1:0] coef_e_i,
  input  logic signed [aif_pkg::COEF_W-1:0] coef_f_i,
  output logic                              valid_o,
  output logic signed [aif_pkg::COEF_W-1:0] inv_a_o,
  output logic signed [aif_pkg::COEF_W-1:0] inv_b_o,
  output logic signed [aif_pkg::COEF_W-1:0] inv_c_o,
  output logic signed [aif_pkg::COEF_W-1:0] inv_d_o,
  output logic signed [aif_pkg::COEF_W-1:0] inv_e_o,
  output logic signed [aif_pkg::COEF_W-1:0] inv_f_o,
  output logic                              singular_o
);
  import aif_pkg::*;

  // The minimum determinant magnitude, in Q0.32, that still counts as invertible.
  logic [COEF_W-1:0]            det_min_q;
  // Stage k of the chain feeds division cell k; the last stage feeds rounding.
  aif_flow_t                    stg [Q_W+1];
  logic [LANES-1:0][COEF_W-1:0] res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_min_q <= DET_MIN_RST;
    end else if (det_min_we_i) begin
      det_min_q <= det_min_i;
    end
  end

  // Every stage is a plain pipeline register, so a new transaction may enter each cycle.
  assign busy_o = 1'b0;

  // Six signed products are registered first; the next register holds the determinant, the two translation
  // numerators, the singular decision and the scaled numerator magnitudes.
  aif_front #(
    .ONE_SHIFT(ONE_SHIFT)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .det_min_i (det_min_q),
    .coef_a_i  (coef_a_i),
    .coef_b_i  (coef_b_i),
    .coef_c_i  (coef_c_i),
    .coef_d_i  (coef_d_i),
    .coef_e_i  (coef_e_i),
    .coef_f_i  (coef_f_i),
    .flow_o    (stg[0])
  );

  // Each cell resolves one quotient bit, most significant first. The first cell
  // weighs the divisor by 2^33 and only marks quotients that must saturate.
  for (genvar k = 0; k < Q_W; k++) begin : g_cell
    aif_div_cell #(
      .SHIFT(Q_W - 1 - k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .flow_i (stg[k]),
      .flow_o (stg[k+1])
    );
  end

  // Round half away from zero, apply the sign, saturate and zero singular results.
  aif_round u_round (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .flow_i     (stg[Q_W]),
    .valid_o    (valid_o),
    .singular_o (singular_o),
    .res_o      (res)
  );

  assign inv_a_o = res[0];
  assign inv_b_o = res[1];
  assign inv_c_o = res[2];
  assign inv_d_o = res[3];
  assign inv_e_o = res[4];
  assign inv_f_o = res[5];

endmodule
